>>> rtl/core/dmc_pkg.sv
// dmc_pkg: shared types, codes and helper functions for the DFS maze carver.
// Used by dmc_ctrl, dmc_datapath and dfs_maze_carver_core; no dependencies.

package dmc_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 4'd1;
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 7'd16;

    // Payload widths of the ports
    localparam int RND_W   = 16;
    localparam int COORD_W = 6;

    // Action codes
    localparam logic [1:0] ACT_CARVED    = 2'd0;
    localparam logic [1:0] ACT_BACKTRACK = 2'd1;
    localparam logic [1:0] ACT_FINISHED  = 2'd2;
    localparam logic [1:0] ACT_IDLE_DONE = 2'd3;

    // Direction codes, also the scan order of the neighbors
    localparam logic [1:0] DIR_NORTH = 2'd0;
    localparam logic [1:0] DIR_SOUTH = 2'd1;
    localparam logic [1:0] DIR_WEST  = 2'd2;
    localparam logic [1:0] DIR_EAST  = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic restart;    // clear position, stack and done flag, rewind sweep
        logic clr_step;   // write one entry of the visited map during the sweep
        logic take_item;  // latch the request and the neighbor bounds
        logic rd_issue;   // read one neighbor's visited bit
        logic decide;     // carve, start a pop, or finish
        logic pop_load;   // move to the cell popped off the stack
        logic out_load;   // move the staged result to the output register
    } t_dmc_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;   // sweep is at its last entry
        logic rd_last;    // last neighbor read is being issued
        logic done;       // maze already finished
        logic pop_go;     // no candidate and a non-empty stack
        logic out_free;   // output register can take a result this cycle
    } t_dmc_status;

    // Remainder modulo 3 of a 16-bit value: base-4 digits are each 1 mod 3
    function automatic logic [1:0] mod3_16(input logic [RND_W-1:0] v);
        logic [4:0] s;
        logic [2:0] f;
        s = '0;
        for (int i = 0; i < RND_W / 2; i++) begin
            s = s + 5'(v[2*i +: 2]);
        end
        f = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
        if (f >= 3'd6) begin
            f = f - 3'd6;
        end else if (f >= 3'd3) begin
            f = f - 3'd3;
        end
        return f[1:0];
    endfunction

endpackage

>>> rtl/core/dmc_ctrl.sv
// dmc_ctrl: sequencer for the maze carver (clearing sweep, neighbor reads,
// decision, pop, result hand-off). Depends on dmc_pkg.

module dmc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_cfg_restart,
    input  dmc_pkg::t_dmc_status i_status,
    output dmc_pkg::t_dmc_cmd    o_cmd,
    output logic                 o_in_stall
);
    import dmc_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_READ   = 7'b0000100,
        S_WAIT   = 7'b0001000,
        S_DECIDE = 7'b0010000,
        S_POP    = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Requests are taken only in idle and never alongside a restart
    assign o_in_stall = (r_state != S_IDLE) || i_cfg_restart;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.take_item = 1'b1;
                    n_state = i_status.done ? S_OUT : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                if (i_status.rd_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state = i_status.pop_go ? S_POP : S_OUT;
            end
            S_POP: begin
                o_cmd.pop_load = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
        // A size write restarts from any state
        if (i_cfg_restart) begin
            o_cmd         = '0;
            o_cmd.restart = 1'b1;
            n_state       = S_CLEAR;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Pops only follow a decision; neighbor reads only follow a request or a read
    a_pop_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop_load |-> $past(o_cmd.decide))
        else $error("pop without a preceding decision");

    a_read_sequence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ($past(o_cmd.take_item) || $past(o_cmd.rd_issue)))
        else $error("neighbor read not started by a request");

    a_stall_outside_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr_step |-> o_in_stall)
        else $error("request window open during the clearing sweep");

endmodule

>>> rtl/core/dmc_datapath.sv
// dmc_datapath: visited map, return stack, position, size registers and the
// output register of the maze carver. Depends on dmc_pkg.

module dmc_datapath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dmc_pkg::t_dmc_cmd                i_cmd,
    output dmc_pkg::t_dmc_status             o_status,
    input  logic                             i_cfg_we,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [dmc_pkg::RND_W-1:0]        i_random_value,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic [1:0]                       o_action,
    output logic [dmc_pkg::COORD_W-1:0]      o_from_row,
    output logic [dmc_pkg::COORD_W-1:0]      o_from_col,
    output logic [dmc_pkg::COORD_W-1:0]      o_to_row,
    output logic [dmc_pkg::COORD_W-1:0]      o_to_col,
    output logic [1:0]                       o_wall_dir
);
    import dmc_pkg::*;

    localparam int RW     = $clog2(MAX_ROWS);
    localparam int CW     = $clog2(MAX_COLS);
    localparam int AW     = RW + CW;
    localparam int VDEPTH = 1 << AW;
    localparam int CELLS  = MAX_ROWS * MAX_COLS;
    localparam int SAW    = $clog2(CELLS);
    localparam int SDW    = $clog2(CELLS + 1);
    localparam int RZW    = (RW + 1 > CFG_DATA_W) ? RW + 1 : CFG_DATA_W;
    localparam int CZW    = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;

    // Size registers
    logic [CFG_DATA_W-1:0] r_rows;
    logic [CFG_DATA_W-1:0] r_cols;

    // Walk state
    logic [RW-1:0]  r_cur_row;
    logic [CW-1:0]  r_cur_col;
    logic [SDW-1:0] r_depth;
    logic           r_done;
    logic [AW-1:0]  r_clr_addr;

    // Per-request registers
    logic [1:0]     r_rnd_lo;
    logic [1:0]     r_rnd_m3;
    logic [3:0]     r_nb_ok;
    logic [3:0]     r_nb_vis;
    logic [1:0]     r_rd_cnt;
    logic [1:0]     r_rd_dir;
    logic           r_rd_pend;

    // Staged result
    logic [1:0]     r_res_action;
    logic [RW-1:0]  r_res_from_row;
    logic [CW-1:0]  r_res_from_col;
    logic [RW-1:0]  r_res_to_row;
    logic [CW-1:0]  r_res_to_col;
    logic [1:0]     r_res_wall;

    // Output register
    logic           r_o_valid;
    logic [1:0]     r_o_action;
    logic [COORD_W-1:0] r_o_from_row;
    logic [COORD_W-1:0] r_o_from_col;
    logic [COORD_W-1:0] r_o_to_row;
    logic [COORD_W-1:0] r_o_to_col;
    logic [1:0]     r_o_wall;

    // Memories
    logic           r_vis_mem [0:VDEPTH-1];
    logic           r_vis_rd;
    logic [AW-1:0]  r_stk_mem [0:CELLS-1];
    logic [AW-1:0]  r_stk_rd;

    // Clamped sizes and neighbor bounds
    logic [RZW-1:0] w_rows_ext;
    logic [RZW-1:0] w_rows_cl;
    logic [CZW-1:0] w_cols_ext;
    logic [CZW-1:0] w_cols_cl;
    logic [3:0]     w_nb_ok;

    always_comb begin
        w_rows_ext = RZW'(r_rows);
        w_cols_ext = CZW'(r_cols);
        if (w_rows_ext == '0) begin
            w_rows_cl = RZW'(1);
        end else if (w_rows_ext > RZW'(MAX_ROWS)) begin
            w_rows_cl = RZW'(MAX_ROWS);
        end else begin
            w_rows_cl = w_rows_ext;
        end
        if (w_cols_ext == '0) begin
            w_cols_cl = CZW'(1);
        end else if (w_cols_ext > CZW'(MAX_COLS)) begin
            w_cols_cl = CZW'(MAX_COLS);
        end else begin
            w_cols_cl = w_cols_ext;
        end
        w_nb_ok[DIR_NORTH] = (r_cur_row != '0);
        w_nb_ok[DIR_SOUTH] = (RZW'(r_cur_row) + RZW'(1)) < w_rows_cl;
        w_nb_ok[DIR_WEST]  = (r_cur_col != '0);
        w_nb_ok[DIR_EAST]  = (CZW'(r_cur_col) + CZW'(1)) < w_cols_cl;
    end

    // Neighbor cell in a given direction (wraps harmlessly when out of bounds)
    logic [RW-1:0] w_rd_row;
    logic [CW-1:0] w_rd_col;
    logic [RW-1:0] w_new_row;
    logic [CW-1:0] w_new_col;

    always_comb begin
        w_rd_row = r_cur_row;
        w_rd_col = r_cur_col;
        case (r_rd_cnt)
            DIR_NORTH: w_rd_row = r_cur_row - RW'(1);
            DIR_SOUTH: w_rd_row = r_cur_row + RW'(1);
            DIR_WEST:  w_rd_col = r_cur_col - CW'(1);
            DIR_EAST:  w_rd_col = r_cur_col + CW'(1);
            default:   w_rd_row = r_cur_row;
        endcase
    end

    // Candidate selection: entry (random mod count) of the unvisited neighbors
    logic [3:0] w_cand;
    logic [2:0] w_cand_cnt;
    logic [1:0] w_sel;
    logic [1:0] w_dir;
    logic [1:0] w_seen;
    logic       w_carve;

    always_comb begin
        w_cand     = r_nb_ok & ~r_nb_vis;
        w_cand_cnt = 3'(w_cand[0]) + 3'(w_cand[1]) + 3'(w_cand[2]) + 3'(w_cand[3]);
        case (w_cand_cnt)
            3'd2:    w_sel = {1'b0, r_rnd_lo[0]};
            3'd3:    w_sel = r_rnd_m3;
            3'd4:    w_sel = r_rnd_lo;
            default: w_sel = 2'd0;
        endcase
        w_dir  = DIR_NORTH;
        w_seen = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (w_cand[i]) begin
                if (w_seen == w_sel) begin
                    w_dir = 2'(i);
                end
                w_seen = w_seen + 2'd1;
            end
        end
        w_carve   = (w_cand_cnt != 3'd0);
        w_new_row = r_cur_row;
        w_new_col = r_cur_col;
        case (w_dir)
            DIR_NORTH: w_new_row = r_cur_row - RW'(1);
            DIR_SOUTH: w_new_row = r_cur_row + RW'(1);
            DIR_WEST:  w_new_col = r_cur_col - CW'(1);
            DIR_EAST:  w_new_col = r_cur_col + CW'(1);
            default:   w_new_row = r_cur_row;
        endcase
    end

    // Status to the controller
    always_comb begin
        o_status.clr_last = &r_clr_addr;
        o_status.rd_last  = (r_rd_cnt == DIR_EAST);
        o_status.done     = r_done;
        o_status.pop_go   = !w_carve && (r_depth != '0);
        o_status.out_free = !r_o_valid || !i_out_stall;
    end

    // Visited map port control
    logic          w_vis_we;
    logic [AW-1:0] w_vis_wa;
    logic          w_vis_wd;
    logic          w_stk_push;

    always_comb begin
        w_vis_we = 1'b0;
        w_vis_wa = r_clr_addr;
        w_vis_wd = 1'b0;
        if (i_cmd.clr_step) begin
            w_vis_we = 1'b1;
            w_vis_wd = (r_clr_addr == '0);   // start cell is visited
        end else if (i_cmd.decide && w_carve && !r_done) begin
            w_vis_we = 1'b1;
            w_vis_wa = {w_new_row, w_new_col};
            w_vis_wd = 1'b1;
        end
        w_stk_push = i_cmd.decide && w_carve && !r_done && (r_depth != SDW'(CELLS));
    end

    // Visited map: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_vis_we) begin
            r_vis_mem[w_vis_wa] <= w_vis_wd;
        end
        if (i_cmd.rd_issue) begin
            r_vis_rd <= r_vis_mem[{w_rd_row, w_rd_col}];
        end
    end

    // Return stack: push at depth, registered pop read at depth - 1
    always_ff @(posedge i_clk) begin
        if (w_stk_push) begin
            r_stk_mem[r_depth[SAW-1:0]] <= {r_cur_row, r_cur_col};
        end
        if (i_cmd.decide && o_status.pop_go) begin
            r_stk_rd <= r_stk_mem[SAW'(r_depth - SDW'(1))];
        end
    end

    // Size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= SIZE_RESET;
            r_cols <= SIZE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end
            if (i_cfg_index == CFG_COLS) begin
                r_cols <= i_cfg_data;
            end
        end
    end

    // Walk state and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_depth    <= '0;
            r_done     <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.decide) begin
                if (w_carve) begin
                    r_cur_row <= w_new_row;
                    r_cur_col <= w_new_col;
                    if (w_stk_push) begin
                        r_depth <= r_depth + SDW'(1);
                    end
                end else if (r_depth != '0) begin
                    r_depth <= r_depth - SDW'(1);
                end else begin
                    r_done <= 1'b1;
                end
            end
            if (i_cmd.pop_load) begin
                r_cur_row <= r_stk_rd[AW-1:CW];
                r_cur_col <= r_stk_rd[CW-1:0];
            end
        end
    end

    // Neighbor read sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt  <= 2'd0;
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_issue;
            if (i_cmd.take_item) begin
                r_rd_cnt <= 2'd0;
            end else if (i_cmd.rd_issue) begin
                r_rd_cnt <= r_rd_cnt + 2'd1;
            end
        end
    end

    // Request payload, bounds and captured visited bits
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_rnd_lo <= i_random_value[1:0];
            r_rnd_m3 <= mod3_16(i_random_value);
            r_nb_ok  <= w_nb_ok;
        end
        if (i_cmd.rd_issue) begin
            r_rd_dir <= r_rd_cnt;
        end
        if (r_rd_pend) begin
            r_nb_vis[r_rd_dir] <= r_vis_rd;
        end
    end

    // Staged result
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_res_action   <= ACT_IDLE_DONE;
            r_res_from_row <= r_cur_row;
            r_res_from_col <= r_cur_col;
            r_res_to_row   <= r_cur_row;
            r_res_to_col   <= r_cur_col;
            r_res_wall     <= DIR_NORTH;
        end
        if (i_cmd.decide) begin
            if (w_carve) begin
                r_res_action <= ACT_CARVED;
                r_res_to_row <= w_new_row;
                r_res_to_col <= w_new_col;
                r_res_wall   <= w_dir;
            end else if (r_depth != '0) begin
                r_res_action <= ACT_BACKTRACK;
            end else begin
                r_res_action <= ACT_FINISHED;
            end
        end
        if (i_cmd.pop_load) begin
            r_res_to_row <= r_stk_rd[AW-1:CW];
            r_res_to_col <= r_stk_rd[CW-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_action   <= r_res_action;
            r_o_from_row <= COORD_W'(r_res_from_row);
            r_o_from_col <= COORD_W'(r_res_from_col);
            r_o_to_row   <= COORD_W'(r_res_to_row);
            r_o_to_col   <= COORD_W'(r_res_to_col);
            r_o_wall     <= r_res_wall;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_action    = r_o_action;
    assign o_from_row  = r_o_from_row;
    assign o_from_col  = r_o_from_col;
    assign o_to_row    = r_o_to_row;
    assign o_to_col    = r_o_to_col;
    assign o_wall_dir  = r_o_wall;

    // A held result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_o_valid || !i_out_stall))
        else $error("output register overwritten while stalled");

    // The stack never holds more than one entry per cell
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= SDW'(CELLS))
        else $error("return stack depth out of range");

    // A finished maze is never walked again
    a_no_decide_when_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |-> !r_done)
        else $error("decision taken after the maze finished");

endmodule

>>> rtl/core/dfs_maze_carver_core.sv
// dfs_maze_carver_core: top level of the randomized depth-first maze carver.
// Instantiates dmc_ctrl and dmc_datapath; depends on dmc_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall, i_random_value): each request is
//   one carver step. Output channel (o_out_valid / i_out_stall): one result
//   per request with the action, the cell before and after, and the wall.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 sets
//   the row count, index 1 the column count; either write restarts the walk.
//   Other indexes are ignored.
// Step sequence:
//   A carve step goes from acceptance to the next acceptance through the
//   accept, four visited-map reads through its single read port, a read-data
//   wait, a decision and a hand-off. A backtrack adds a registered stack read
//   before the hand-off. Once finished, a step goes from the accept straight
//   to the hand-off. Results leave through an output register.
// Reset and restart:
//   After reset or a size write, all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS))
//   visited-map entries (4096 at defaults) are swept one entry a cycle, while
//   o_in_stall stays high. A stalled result holds; the next request can be
//   taken meanwhile, and its result waits until the output register frees.

module dfs_maze_carver_core #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [dmc_pkg::RND_W-1:0]      i_random_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_action,
    output logic [dmc_pkg::COORD_W-1:0]    o_from_row,
    output logic [dmc_pkg::COORD_W-1:0]    o_from_col,
    output logic [dmc_pkg::COORD_W-1:0]    o_to_row,
    output logic [dmc_pkg::COORD_W-1:0]    o_to_col,
    output logic [1:0]                     o_wall_dir,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dmc_pkg::*;

    t_dmc_cmd    w_cmd;
    t_dmc_status w_status;
    logic        w_cfg_we;
    logic        w_cfg_restart;

    // Config writes are always taken; only the size registers restart
    assign o_cfg_ready   = 1'b1;
    assign w_cfg_we      = i_cfg_valid && o_cfg_ready;
    assign w_cfg_restart = w_cfg_we && ((i_cfg_index == CFG_ROWS) ||
                                        (i_cfg_index == CFG_COLS));

    dmc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_cfg_restart (w_cfg_restart),
        .i_status      (w_status),
        .o_cmd         (w_cmd),
        .o_in_stall    (o_in_stall)
    );

    dmc_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_cfg_we       (w_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_random_value (i_random_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_action       (o_action),
        .o_from_row     (o_from_row),
        .o_from_col     (o_from_col),
        .o_to_row       (o_to_row),
        .o_to_col       (o_to_col),
        .o_wall_dir     (o_wall_dir)
    );

endmodule

>>> sim/dfs_maze_carver_core_tb.sv
`timescale 1ns / 1ps
// dfs_maze_carver_core_tb: self-checking bench for the depth-first maze carver core.
// Checks every step result against a walk tracked alongside; depends on dmc_pkg and the core.

module dfs_maze_carver_core_tb;
    import dmc_pkg::*;

    localparam int GRID_ROWS      = 64;
    localparam int GRID_COLS      = 64;
    localparam int GRID_CELLS     = GRID_ROWS * GRID_COLS;
    localparam int CLK_PERIOD     = 12;
    localparam int CLK_HALF       = CLK_PERIOD / 2;
    localparam int RESET_CYCLES   = 9;
    localparam int STEP_TARGET    = 1150;
    localparam int DRAIN_CYCLES   = 16;
    localparam int QUIET_TAIL     = 120;
    localparam int LONG_HOLD_AT   = 200;
    localparam int LONG_HOLD_LEN  = 300;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int PRINT_LIMIT    = 50;

    // Register indexes the core does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 4'd9;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP   = 4'hF;

    typedef enum logic [1:0] {REQ_STEP, REQ_CFG, REQ_DRAIN} t_req_kind;

    typedef struct {
        t_req_kind              kind;
        logic [RND_W-1:0]       rnd;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
    } t_request;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] from_row;
        logic [COORD_W-1:0] from_col;
        logic [COORD_W-1:0] to_row;
        logic [COORD_W-1:0] to_col;
        logic [1:0]         wall_dir;
    } t_step_result;

    typedef enum logic [2:0] {
        DRV_IDLE, DRV_GAP, DRV_OFFER, DRV_CFG_WAIT, DRV_CFG_WRITE, DRV_CFG_SETTLE, DRV_DRAIN
    } t_drv_state;

    // DUT inputs, known from time zero
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic [RND_W-1:0]       i_random_value = '0;
    logic                   i_out_stall = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [1:0]             o_action;
    logic [COORD_W-1:0]     o_from_row;
    logic [COORD_W-1:0]     o_from_col;
    logic [COORD_W-1:0]     o_to_row;
    logic [COORD_W-1:0]     o_to_col;
    logic [1:0]             o_wall_dir;
    logic                   o_cfg_ready;

    dfs_maze_carver_core #(
        .MAX_ROWS(GRID_ROWS),
        .MAX_COLS(GRID_COLS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_random_value(i_random_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_action(o_action),
        .o_from_row(o_from_row),
        .o_from_col(o_from_col),
        .o_to_row(o_to_row),
        .o_to_col(o_to_col),
        .o_wall_dir(o_wall_dir),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Request plan and bookkeeping
    t_request       request_queue[$];
    t_step_result   step_results_due[$];
    int             steps_total = 0;
    int             steps_offered = 0;
    int             steps_taken = 0;
    int             cfg_offered = 0;
    int             cfg_taken = 0;
    int             results_seen = 0;
    int             mismatch_count = 0;
    bit             quiet_mode = 1'b0;
    bit             in_stall_seen = 1'b1;
    logic [6:0]     plan_rows = SIZE_RESET;
    logic [6:0]     plan_cols = SIZE_RESET;

    // Walk state mirrored from the core
    logic [6:0]         rows_reg = SIZE_RESET;
    logic [6:0]         cols_reg = SIZE_RESET;
    bit                 visited_cells [GRID_CELLS];
    logic [11:0]        return_trail [GRID_CELLS];
    int unsigned        trail_len;
    logic [COORD_W-1:0] at_row;
    logic [COORD_W-1:0] at_col;
    bit                 walk_done;

    function automatic int unsigned effective_size(input logic [6:0] v, input int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    task automatic restart_walk();
        foreach (visited_cells[k]) visited_cells[k] = 1'b0;
        visited_cells[0] = 1'b1;
        trail_len = 0;
        at_row = '0;
        at_col = '0;
        walk_done = 1'b0;
    endtask

    // One carver step: carve to a random unvisited neighbor, backtrack, or finish
    task automatic advance_walk(input logic [RND_W-1:0] rnd, output t_step_result res);
        int unsigned n_rows;
        int unsigned n_cols;
        int unsigned r;
        int unsigned c;
        int unsigned count;
        int unsigned trail_entry;
        logic [1:0]  cand [4];
        logic [1:0]  dir;
        res.from_row = at_row;
        res.from_col = at_col;
        res.wall_dir = DIR_NORTH;
        if (walk_done) begin
            res.action = ACT_IDLE_DONE;
        end else begin
            n_rows = effective_size(rows_reg, GRID_ROWS);
            n_cols = effective_size(cols_reg, GRID_COLS);
            r = at_row;
            c = at_col;
            count = 0;
            // neighbor scan order: north, south, west, east
            if (r > 0 && !visited_cells[(r - 1) * GRID_COLS + c]) begin
                cand[count] = DIR_NORTH;
                count = count + 1;
            end
            if (r + 1 < n_rows && !visited_cells[(r + 1) * GRID_COLS + c]) begin
                cand[count] = DIR_SOUTH;
                count = count + 1;
            end
            if (c > 0 && !visited_cells[r * GRID_COLS + c - 1]) begin
                cand[count] = DIR_WEST;
                count = count + 1;
            end
            if (c + 1 < n_cols && !visited_cells[r * GRID_COLS + c + 1]) begin
                cand[count] = DIR_EAST;
                count = count + 1;
            end
            if (count != 0) begin
                dir = cand[rnd % count];
                if (trail_len < GRID_CELLS) begin
                    return_trail[trail_len] = 12'(r * GRID_COLS + c);
                    trail_len = trail_len + 1;
                end
                case (dir)
                    DIR_NORTH: r = r - 1;
                    DIR_SOUTH: r = r + 1;
                    DIR_WEST:  c = c - 1;
                    default:   c = c + 1;
                endcase
                visited_cells[r * GRID_COLS + c] = 1'b1;
                at_row = COORD_W'(r);
                at_col = COORD_W'(c);
                res.wall_dir = dir;
                res.action = ACT_CARVED;
            end else if (trail_len != 0) begin
                trail_len = trail_len - 1;
                trail_entry = return_trail[trail_len];
                at_row = COORD_W'(trail_entry / GRID_COLS);
                at_col = COORD_W'(trail_entry % GRID_COLS);
                res.action = ACT_BACKTRACK;
            end else begin
                walk_done = 1'b1;
                res.action = ACT_FINISHED;
            end
        end
        res.to_row = at_row;
        res.to_col = at_col;
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] MISMATCH: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [COORD_W-1:0] got,
                               input logic [COORD_W-1:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_seen, name, got, want));
        end
    endtask

    // Plan helpers
    task automatic add_step(input logic [RND_W-1:0] rnd);
        t_request req;
        req.kind = REQ_STEP;
        req.rnd = rnd;
        req.idx = '0;
        req.data = '0;
        request_queue.push_back(req);
        steps_total++;
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_request req;
        req.kind = REQ_CFG;
        req.rnd = '0;
        req.idx = idx;
        req.data = data;
        request_queue.push_back(req);
        if (idx == CFG_ROWS) plan_rows = data;
        if (idx == CFG_COLS) plan_cols = data;
    endtask

    task automatic add_drain();
        t_request req;
        req.kind = REQ_DRAIN;
        req.rnd = '0;
        req.idx = '0;
        req.data = '0;
        request_queue.push_back(req);
    endtask

    // Mostly small grids, sometimes anything the register holds
    function automatic logic [CFG_DATA_W-1:0] pick_size();
        if ($urandom_range(0, 99) < 80) return CFG_DATA_W'($urandom_range(1, 6));
        return CFG_DATA_W'($urandom_range(0, 127));
    endfunction

    // Request driver: steps, register writes and pauses, changed at the falling edge
    t_drv_state drive_state = DRV_IDLE;
    t_request   active_req;
    int         gap_left = 0;
    int         wait_left = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            case (drive_state)
                DRV_IDLE: begin
                    if (request_queue.size() != 0) begin
                        active_req = request_queue.pop_front();
                        case (active_req.kind)
                            REQ_STEP: begin
                                i_in_valid <= 1'b1;
                                i_random_value <= active_req.rnd;
                                steps_offered++;
                                drive_state = DRV_OFFER;
                            end
                            REQ_CFG: begin
                                wait_left = DRAIN_CYCLES;
                                drive_state = DRV_CFG_WAIT;
                            end
                            default: drive_state = DRV_DRAIN;
                        endcase
                    end
                end
                DRV_GAP: begin
                    gap_left--;
                    if (gap_left <= 0) drive_state = DRV_IDLE;
                end
                DRV_OFFER: begin
                    // request taken at the last rising edge
                    if (steps_taken == steps_offered) begin
                        if (!quiet_mode && $urandom_range(0, 99) < 20) begin
                            i_in_valid <= 1'b0;
                            gap_left = $urandom_range(1, 12);
                            drive_state = DRV_GAP;
                        end else if (request_queue.size() != 0 &&
                                     request_queue[0].kind == REQ_STEP) begin
                            active_req = request_queue.pop_front();
                            i_random_value <= active_req.rnd;
                            steps_offered++;
                        end else begin
                            i_in_valid <= 1'b0;
                            drive_state = DRV_IDLE;
                        end
                    end
                end
                DRV_CFG_WAIT: begin
                    // write only once the core has gone quiet
                    if (step_results_due.size() != 0) begin
                        wait_left = DRAIN_CYCLES;
                    end else if (wait_left > 0) begin
                        wait_left--;
                    end else begin
                        i_cfg_valid <= 1'b1;
                        i_cfg_index <= active_req.idx;
                        i_cfg_data <= active_req.data;
                        cfg_offered++;
                        drive_state = DRV_CFG_WRITE;
                    end
                end
                DRV_CFG_WRITE: begin
                    if (cfg_taken == cfg_offered) begin
                        i_cfg_valid <= 1'b0;
                        wait_left = 2;
                        drive_state = DRV_CFG_SETTLE;
                    end
                end
                DRV_CFG_SETTLE: begin
                    // let the visited-map clear finish before anything else
                    if (wait_left > 0) wait_left--;
                    else if (!in_stall_seen) drive_state = DRV_IDLE;
                end
                default: begin
                    if (step_results_due.size() == 0) drive_state = DRV_IDLE;
                end
            endcase
        end
    end

    // Result receiver: random stall bursts, one long hold to back the core up
    int stall_left = 0;
    bit long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!long_hold_done && steps_taken >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_LEN;
            end else if (stall_left == 0 && !quiet_mode && $urandom_range(0, 99) < 8) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Monitor: predicts on each accepted request, checks each accepted result
    t_step_result got_res;
    t_step_result want_res;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_reg = SIZE_RESET;
            cols_reg = SIZE_RESET;
            restart_walk();
        end else begin
            in_stall_seen = o_in_stall;
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (step_results_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with no request pending",
                                              results_seen));
                end else begin
                    want_res = step_results_due.pop_front();
                    check_field("action", COORD_W'(o_action), COORD_W'(want_res.action));
                    check_field("from_row", o_from_row, want_res.from_row);
                    check_field("from_col", o_from_col, want_res.from_col);
                    check_field("to_row", o_to_row, want_res.to_row);
                    check_field("to_col", o_to_col, want_res.to_col);
                    check_field("wall_dir", COORD_W'(o_wall_dir),
                                COORD_W'(want_res.wall_dir));
                end
                results_seen++;
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                if (i_cfg_index == CFG_ROWS) begin
                    rows_reg = i_cfg_data;
                    restart_walk();
                end else if (i_cfg_index == CFG_COLS) begin
                    cols_reg = i_cfg_data;
                    restart_walk();
                end
                cfg_taken++;
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                advance_walk(i_random_value, got_res);
                step_results_due.push_back(got_res);
                steps_taken++;
            end
            quiet_mode = (steps_total - steps_taken) < QUIET_TAIL;
        end
    end

    // Stimulus plan, reset and end of run
    initial begin
        int unsigned cells;
        int          n_steps;
        int          guard;

        // default 16 x 16 grid, extremes of the random value
        add_step(16'h0000);
        add_step(16'hFFFF);
        add_step(16'h5555);
        add_step(16'hAAAA);
        add_step(16'h0001);
        add_step(16'h0002);
        add_drain();
        add_step(16'h0003);
        // undecoded indexes change nothing, the walk goes on
        add_cfg(CFG_IDX_TOP, 7'd127);
        add_cfg(CFG_IDX_SPARE, 7'd0);
        add_step(16'h8000);
        add_step(16'h7FFF);
        // zero sizes act as one: finish at once, then stay finished
        add_cfg(CFG_ROWS, 7'd0);
        add_cfg(CFG_COLS, 7'd0);
        add_step(16'h1234);
        add_step(16'hFFFF);
        // 1 x 2: carve, backtrack, finish, stay finished
        add_cfg(CFG_COLS, 7'd2);
        for (int k = 0; k < 4; k++) add_step(16'($urandom_range(0, 65535)));
        // same value again still restarts
        add_cfg(CFG_COLS, 7'd2);
        add_step(16'h0000);
        add_step(16'h0000);
        // oversize values clamp to the full grid
        add_cfg(CFG_ROWS, 7'd127);
        add_cfg(CFG_COLS, 7'd65);
        add_step(16'hFFFF);
        add_step(16'h0000);
        add_step(16'hC3C3);
        add_step(16'h3C3C);
        // one tall column
        add_cfg(CFG_ROWS, 7'd64);
        add_cfg(CFG_COLS, 7'd1);
        for (int k = 0; k < 3; k++) add_step(16'($urandom_range(0, 65535)));

        // random sizes; small grids are walked to the end and past it
        while (steps_total < STEP_TARGET) begin
            case ($urandom_range(0, 3))
                0: add_cfg(CFG_ROWS, pick_size());
                1: add_cfg(CFG_COLS, pick_size());
                default: begin
                    add_cfg(CFG_ROWS, pick_size());
                    add_cfg(CFG_COLS, pick_size());
                end
            endcase
            cells = effective_size(plan_rows, GRID_ROWS) * effective_size(plan_cols, GRID_COLS);
            if (cells <= 36) n_steps = 2 * cells - 1 + $urandom_range(1, 3);
            else n_steps = $urandom_range(20, 60);
            for (int k = 0; k < n_steps; k++) add_step(16'($urandom_range(0, 65535)));
            if ($urandom_range(0, 9) == 0) add_drain();
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (steps_taken == steps_total);
        for (guard = 0; guard < 4000 && step_results_due.size() != 0; guard++) begin
            @(posedge i_clk);
        end
        if (step_results_due.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", step_results_due.size()));
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[%0t] timeout: %0d of %0d requests taken", $time, steps_taken, steps_total);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
